/* rtl/rtt_pkg.sv */
// Shared types, widths and constants of the resistance to temperature linearizer.
// Holds the factory calibration curve and the request/response structs of the arithmetic unit.
// No dependencies.
package rtt_pkg;

	localparam int RES_W = 19;
	localparam int IDX_W = 6;
	localparam int TEMP_W = 16;
	localparam int OUT_W = 26;
	localparam int PROD_W = OUT_W + RES_W;
	localparam int CNT_W = $clog2(OUT_W);
	localparam int POINTS_DEF = 64;
	localparam int CURVE_LEN = 64;

	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// factory curve, resistance in 0.1 ohm
	localparam logic [RES_W-1:0] CURVE_RES [CURVE_LEN] = '{
		19'd11037, 19'd11079, 19'd11126, 19'd11179, 19'd11236, 19'd11302, 19'd11377, 19'd11463,
		19'd11565, 19'd11683, 19'd11822, 19'd11904, 19'd11993, 19'd12093, 19'd12204, 19'd12331,
		19'd12472, 19'd12637, 19'd12826, 19'd13050, 19'd13314, 19'd13434, 19'd13564, 19'd13704,
		19'd13859, 19'd14025, 19'd14211, 19'd14415, 19'd14633, 19'd14880, 19'd15159, 19'd15476,
		19'd15845, 19'd16299, 19'd16814, 19'd17407, 19'd17746, 19'd18124, 19'd18544, 19'd19015,
		19'd19537, 19'd20115, 19'd20793, 19'd21604, 19'd22566, 19'd23681, 19'd25087, 19'd26799,
		19'd29022, 19'd31935, 19'd36025, 19'd38751, 19'd42228, 19'd46290, 19'd52287, 19'd60815,
		19'd73985, 19'd97497, 19'd153150, 19'd175540, 19'd205230, 19'd237230, 19'd295680,
		19'd378860
	};

	// factory curve, temperature in mK
	localparam logic [TEMP_W-1:0] CURVE_TEMP [CURVE_LEN] = '{
		16'd20000, 16'd19000, 16'd18000, 16'd17000, 16'd16000, 16'd15000, 16'd14000, 16'd13000,
		16'd12000, 16'd11000, 16'd10000, 16'd9500, 16'd9000, 16'd8500, 16'd8000, 16'd7500,
		16'd7000, 16'd6500, 16'd6000, 16'd5500, 16'd5000, 16'd4800, 16'd4600, 16'd4400,
		16'd4200, 16'd4000, 16'd3800, 16'd3600, 16'd3400, 16'd3200, 16'd3000, 16'd2800,
		16'd2600, 16'd2400, 16'd2200, 16'd2000, 16'd1900, 16'd1800, 16'd1700, 16'd1600,
		16'd1500, 16'd1400, 16'd1300, 16'd1200, 16'd1100, 16'd1000, 16'd900, 16'd800,
		16'd700, 16'd600, 16'd500, 16'd450, 16'd400, 16'd350, 16'd300, 16'd250,
		16'd200, 16'd150, 16'd100, 16'd90, 16'd80, 16'd70, 16'd60, 16'd50
	};

	typedef struct packed {
		logic start;
		logic [RES_W-1:0] r;
		logic [RES_W-1:0] r0;
		logic [RES_W-1:0] r1;
		logic [TEMP_W-1:0] t0;
		logic [TEMP_W-1:0] t1;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic [OUT_W-1:0] value;
	} md_rsp_t;

	// entries past the curve repeat its last point
	function automatic logic [RES_W-1:0] curve_res_at(input logic [7:0] idx);
		return (idx < 8'(CURVE_LEN)) ? CURVE_RES[idx[5:0]] : CURVE_RES[CURVE_LEN-1];
	endfunction

	function automatic logic [TEMP_W-1:0] curve_temp_at(input logic [7:0] idx);
		return (idx < 8'(CURVE_LEN)) ? CURVE_TEMP[idx[5:0]] : CURVE_TEMP[CURVE_LEN-1];
	endfunction

	// x * 1000 as 1024 - 16 - 8
	function automatic logic [OUT_W-1:0] mul1000(input logic [TEMP_W-1:0] x);
		logic [OUT_W-1:0] w;
		w = OUT_W'(x);
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

/* rtl/rtt_table.sv */
// Calibration point store: resistance and temperature memories with registered read.
// Entries never written read back as the factory curve. Depends on rtt_pkg.
module rtt_table #(
	parameter int POINTS = rtt_pkg::POINTS_DEF,
	localparam int AW = $clog2(POINTS)
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [rtt_pkg::RES_W-1:0] wr_res,
	input logic [rtt_pkg::TEMP_W-1:0] wr_temp,
	input logic [AW-1:0] rd_addr,
	output logic [rtt_pkg::RES_W-1:0] rd_res,
	output logic [rtt_pkg::TEMP_W-1:0] rd_temp
);
	import rtt_pkg::*;

	logic [RES_W-1:0] res_mem [POINTS];
	logic [TEMP_W-1:0] temp_mem [POINTS];
	logic [POINTS-1:0] valid_q;
	logic valid_s1;
	logic [RES_W-1:0] res_s1;
	logic [RES_W-1:0] curve_res_s1;
	logic [TEMP_W-1:0] temp_s1;
	logic [TEMP_W-1:0] curve_temp_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			res_mem[wr_addr] <= wr_res;
			temp_mem[wr_addr] <= wr_temp;
		end
		res_s1 <= res_mem[rd_addr];
		temp_s1 <= temp_mem[rd_addr];
		curve_res_s1 <= curve_res_at(8'(rd_addr));
		curve_temp_s1 <= curve_temp_at(8'(rd_addr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			valid_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_res = valid_s1 ? res_s1 : curve_res_s1;
	assign rd_temp = valid_s1 ? temp_s1 : curve_temp_s1;

endmodule

/* rtl/rtt_muldiv.sv */
// Bit-serial interpolation unit: T0*1000 + (T1-T0)*1000*(R-R0)/(R1-R0), truncated.
// Shift-add multiply, one bit per cycle, then restoring divide, one bit per cycle. Depends on rtt_pkg.
module rtt_muldiv (
	input logic clk,
	input logic arst_n,
	input rtt_pkg::md_req_t req,
	output rtt_pkg::md_rsp_t rsp
);
	import rtt_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL = 4'b0010,
		M_DIV = 4'b0100,
		M_SUM = 4'b1000
	} md_state_t;

	md_state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0] acc_q;
	logic [OUT_W-1:0] mcand_q;
	logic [OUT_W-1:0] t0k_q;
	logic [RES_W-1:0] span_q;
	logic neg_q;
	logic done_q;
	logic [OUT_W-1:0] value_q;
	logic [RES_W-1:0] span_d;
	logic neg_d;
	logic [TEMP_W-1:0] mag_d;
	logic [OUT_W:0] add_sum;
	logic [RES_W:0] trial;
	logic [RES_W:0] trial_diff;
	logic take;
	logic [OUT_W-1:0] quot;

	assign span_d = req.r1 - req.r0;
	assign neg_d = req.t1 < req.t0;
	assign mag_d = neg_d ? (req.t0 - req.t1) : (req.t1 - req.t0);

	// multiply: high half accumulates, low half shifts the multiplier out
	assign add_sum = {1'b0, acc_q[PROD_W-1:RES_W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	// divide: high bits are the partial remainder, low bits dividend in / quotient out
	assign trial = {acc_q[PROD_W-1:OUT_W], acc_q[OUT_W-1]};
	assign take = trial >= {1'b0, span_q};
	assign trial_diff = trial - {1'b0, span_q};
	assign quot = acc_q[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						// zero span: R equals R0, product is zero, skip straight to the sum
						state_q <= (span_d == '0) ? M_SUM : M_MUL;
						cnt_q <= CNT_W'(RES_W - 1);
					end
				end
				M_MUL: begin
					if (cnt_q == '0) begin
						state_q <= M_DIV;
						cnt_q <= CNT_W'(OUT_W - 1);
					end else
						cnt_q <= cnt_q - 1'b1;
				end
				M_DIV: begin
					if (cnt_q == '0)
						state_q <= M_SUM;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				M_SUM: begin
					done_q <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (req.start) begin
					acc_q <= {{OUT_W{1'b0}}, req.r - req.r0};
					mcand_q <= mul1000(mag_d);
					t0k_q <= mul1000(req.t0);
					span_q <= span_d;
					neg_q <= neg_d;
				end
			end
			M_MUL: acc_q <= {add_sum, acc_q[RES_W-1:1]};
			M_DIV: begin
				acc_q <= {take ? trial_diff[RES_W-1:0] : trial[RES_W-1:0],
					acc_q[OUT_W-2:0], take};
			end
			M_SUM: value_q <= t0k_q + (neg_q ? (~quot + 1'b1) : quot);
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.value = value_q;

endmodule

/* rtl/resistance_to_temperature_linearizer.sv */
// A write beat leaves the block idle and ready for the next beat; a convert beat scans the
// table, then multiplies and divides (both skipped on a zero-span segment); an out-of-range
// reading scans every point. Throughput: one item at a time; set by the table scan (one point
// per cycle through the memory read port) plus a bit-serial multiply and a bit-serial divide.
// Reset (arst_n low, asynchronous) empties the pipeline and returns every point to the
// factory curve at once through per-entry valid bits; no clearing pass is needed.
module resistance_to_temperature_linearizer #(
	parameter int POINTS = rtt_pkg::POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic operation,
	input logic [rtt_pkg::RES_W-1:0] resistance,
	input logic [rtt_pkg::IDX_W-1:0] point_index,
	input logic [rtt_pkg::TEMP_W-1:0] point_temperature,
	output logic result_valid,
	input logic result_ready,
	output logic [rtt_pkg::OUT_W-1:0] temperature_uk,
	output logic out_of_range
);
	import rtt_pkg::*;

	localparam int AW = $clog2(POINTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(POINTS - 1);

	// IDLE takes beats, SCAN walks the table, CALC waits on the arithmetic unit,
	// FIN holds the finished result until the output register is free.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_CALC = 4'b0100,
		S_FIN = 4'b1000
	} state_t;

	state_t state_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] idx_s1;
	logic live_s1;
	logic [RES_W-1:0] r_q;
	logic [RES_W-1:0] prev_r_q;
	logic [TEMP_W-1:0] prev_t_q;
	logic [OUT_W-1:0] pend_val_q;
	logic pend_oor_q;
	logic result_valid_q;
	logic [OUT_W-1:0] temp_out_q;
	logic oor_out_q;

	logic accept;
	logic wr_ok;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [RES_W-1:0] rd_res;
	logic [TEMP_W-1:0] rd_temp;
	logic seg_check;
	logic hit;
	logic miss;
	logic out_free;
	md_req_t md_req;
	md_rsp_t md_rsp;

	// ---- input side ----
	assign item_ready = (state_q == S_IDLE);
	assign accept = item_valid && item_ready;

	// writes past the table depth are dropped
	assign wr_ok = 32'(point_index) < 32'(POINTS);
	assign wr_en = accept && (operation == OP_WRITE) && wr_ok;
	assign wr_addr = AW'(point_index);

	rtt_table #(.POINTS(POINTS)) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_res(resistance),
		.wr_temp(point_temperature),
		.rd_addr(addr_q),
		.rd_res(rd_res),
		.rd_temp(rd_temp)
	);

	// ---- scan ----
	// Read data arrives in the cycle after the address; idx_s1 tags it. Point 0 only
	// primes prev_*; every later point closes segment (idx-1, idx). The first segment
	// in index order that holds the reading wins, so an unsorted table still behaves.
	assign seg_check = (state_q == S_SCAN) && live_s1 && (idx_s1 != '0);
	assign hit = seg_check && (prev_r_q <= r_q) && (r_q <= rd_res);
	assign miss = seg_check && !hit && (idx_s1 == LAST_IDX);

	always_comb begin
		md_req.start = hit;
		md_req.r = r_q;
		md_req.r0 = prev_r_q;
		md_req.r1 = rd_res;
		md_req.t0 = prev_t_q;
		md_req.t1 = rd_temp;
	end

	rtt_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.rsp(md_rsp)
	);

	// ---- output register ----
	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			live_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_CONVERT))
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit)
						state_q <= S_CALC;
					else if (miss)
						state_q <= S_FIN;
				end
				S_CALC: begin
					if (md_rsp.done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if ((state_q == S_FIN) && out_free)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_q <= resistance;
			addr_q <= '0;
		end else if ((state_q == S_SCAN) && (addr_q != LAST_IDX))
			addr_q <= addr_q + 1'b1;
		idx_s1 <= addr_q;
		if ((state_q == S_SCAN) && live_s1) begin
			prev_r_q <= rd_res;
			prev_t_q <= rd_temp;
		end
		if (miss) begin
			pend_val_q <= '0;
			pend_oor_q <= 1'b1;
		end else if (md_rsp.done) begin
			pend_val_q <= md_rsp.value;
			pend_oor_q <= 1'b0;
		end
		if ((state_q == S_FIN) && out_free) begin
			temp_out_q <= pend_val_q;
			oor_out_q <= pend_oor_q;
		end
	end

	assign result_valid = result_valid_q;
	assign temperature_uk = temp_out_q;
	assign out_of_range = oor_out_q;

`ifndef ASSERT_OFF
	// the arithmetic unit only finishes while the sequencer waits for it
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == S_CALC))
		else $error("arithmetic result outside CALC");

	// a write beat never leaves the block busy
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == OP_WRITE)) |=> item_ready)
		else $error("write beat did not return to idle");

	// an out-of-range result carries zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_of_range) |-> (temperature_uk == '0))
		else $error("out-of-range result with nonzero temperature");
`endif

endmodule

/* test/resistance_to_temperature_linearizer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for resistance_to_temperature_linearizer: convert and point-write
// beats under random idling and back-pressure, checked against an in-bench interpolator.
// Depends on rtt_pkg and the linearizer RTL.
module resistance_to_temperature_linearizer_tb;
	import rtt_pkg::*;

	localparam int NPOINTS = POINTS_DEF;
	localparam logic [RES_W-1:0] RES_MAX = '1;
	localparam int LONG_HOLD = 300;     // receiver hold-off for the back-pressure test
	localparam int DRAIN_CYCLES = 200;  // extra wait once no results are pending
	localparam int STALL_LIMIT = 4000;  // cycles without any beat before giving up

	typedef struct packed {
		logic [OUT_W-1:0] temperature_uk;
		logic out_of_range;
	} reading_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	logic operation;
	logic [RES_W-1:0] resistance;
	logic [IDX_W-1:0] point_index;
	logic [TEMP_W-1:0] point_temperature;
	logic result_valid;
	logic result_ready;
	logic [OUT_W-1:0] temperature_uk;
	logic out_of_range;

	// bench copy of the calibration table, updated when a write beat is accepted
	logic [RES_W-1:0] cal_res [NPOINTS];
	logic [TEMP_W-1:0] cal_temp [NPOINTS];
	reading_t expected_readings [$];

	int mismatches = 0;
	int idle_cycles = 0;
	bit idle_enable = 1'b1;  // cleared for stretches with no idling on either side
	int holds_requested = 0;
	int holds_served = 0;

	resistance_to_temperature_linearizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.resistance(resistance),
		.point_index(point_index),
		.point_temperature(point_temperature),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.temperature_uk(temperature_uk),
		.out_of_range(out_of_range)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Interpolate a reading on the bench table: first segment (i-1, i) with
	// R[i-1] <= r <= R[i], ends included; a zero-span segment gives its first point.
	function automatic reading_t interpolate_reading(input logic [RES_W-1:0] r);
		reading_t rd;
		longint r0, r1, t0k, t1k, v;
		rd.temperature_uk = '0;
		rd.out_of_range = 1'b1;
		for (int i = 1; i < NPOINTS; i++) begin
			if (r >= cal_res[i-1] && r <= cal_res[i]) begin
				r0 = longint'(cal_res[i-1]);
				r1 = longint'(cal_res[i]);
				t0k = longint'(cal_temp[i-1]) * 1000;
				t1k = longint'(cal_temp[i]) * 1000;
				// signed longint division truncates toward zero
				if (r1 == r0)
					v = t0k;
				else
					v = t0k + ((t1k - t0k) * (longint'(r) - r0)) / (r1 - r0);
				rd.temperature_uk = v[OUT_W-1:0];
				rd.out_of_range = 1'b0;
				return rd;
			end
		end
		return rd;
	endfunction

	// Both channels are sampled here, at the edge, with pre-edge values. The input beat
	// is handled first so a table write is seen by any later prediction.
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			for (int i = 0; i < NPOINTS; i++) begin
				cal_res[i] = CURVE_RES[i];
				cal_temp[i] = CURVE_TEMP[i];
			end
		end else begin
			if (item_valid && item_ready) begin
				if (operation == OP_WRITE) begin
					cal_res[point_index] = resistance;
					cal_temp[point_index] = point_temperature;
				end else begin
					expected_readings.push_back(interpolate_reading(resistance));
				end
			end
			if (result_valid && result_ready) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected result beat: temperature_uk %0d out_of_range %0b",
						temperature_uk, out_of_range);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					if (temperature_uk !== want.temperature_uk) begin
						$error("temperature_uk: expected %0d, got %0d",
							want.temperature_uk, temperature_uk);
						mismatches++;
					end
					if (out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %0b, got %0b",
							want.out_of_range, out_of_range);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: any beat on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Result side: draw a gap per beat, then hold ready until a beat lands. A pending
	// hold request replaces the gap with a long stretch of ready low.
	initial begin : result_side
		int gap;
		result_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = idle_enable ? $urandom_range(7, 0) : 0;
			if (holds_served < holds_requested) begin
				holds_served++;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_valid);
		end
	end

	// Offer one beat after a random gap and wait for it to be taken.
	task automatic send_beat(input logic op, input logic [RES_W-1:0] r,
			input logic [IDX_W-1:0] idx, input logic [TEMP_W-1:0] t);
		int gap;
		gap = idle_enable ? $urandom_range(7, 0) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		resistance <= r;
		point_index <= idx;
		point_temperature <= t;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	// unused fields of a convert beat carry random bits
	task automatic convert(input logic [RES_W-1:0] r);
		send_beat(OP_CONVERT, r, IDX_W'($urandom), TEMP_W'($urandom));
	endtask

	task automatic write_point(input logic [IDX_W-1:0] idx, input logic [RES_W-1:0] r,
			input logic [TEMP_W-1:0] t);
		send_beat(OP_WRITE, r, idx, t);
	endtask

	// Reading mix: mostly inside the table span, some exactly on a point, some anywhere.
	task automatic convert_random();
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 60 && cal_res[0] <= cal_res[NPOINTS-1])
			convert(RES_W'($urandom_range(cal_res[NPOINTS-1], cal_res[0])));
		else if (pick < 75)
			convert(cal_res[$urandom_range(NPOINTS-1, 0)]);
		else
			convert(RES_W'($urandom_range(RES_MAX, 0)));
	endtask

	// Factory curve: below, on and above both ends, on an inner point, between points.
	task automatic test_factory_curve();
		convert('0);
		convert(CURVE_RES[0] - 1'b1);
		convert(CURVE_RES[0]);
		convert(RES_W'(12000));
		convert(CURVE_RES[32]);
		convert(RES_W'(100000));
		convert(CURVE_RES[CURVE_LEN-1]);
		convert(CURVE_RES[CURVE_LEN-1] + 1'b1);
		convert(RES_MAX);
	endtask

	// Point writes: zero-span segment, full-scale ends, a table made unsorted.
	task automatic test_point_writes();
		write_point(IDX_W'(1), CURVE_RES[0], 16'd19000);   // points 0 and 1 coincide
		convert(CURVE_RES[0]);
		write_point(IDX_W'(0), '0, '1);                     // hottest point at zero ohms
		convert('0);
		convert(RES_W'(5000));
		write_point(IDX_W'(NPOINTS-1), RES_MAX, '0);        // coldest point at full scale
		convert(RES_MAX);
		convert(RES_W'(400000));
		write_point(IDX_W'(10), RES_W'(200000), 16'd123);   // out of order: spans many points
		convert(RES_W'(150000));
		convert(RES_W'(11800));
		write_point(IDX_W'(10), CURVE_RES[10], CURVE_TEMP[10]);
		convert(RES_W'(11800));
	endtask

	// Rewrite the whole table as a random rising curve, then read it. The first round
	// spans the full resistance range; zero steps make zero-span segments.
	task automatic test_random_curves(input int rounds, input int reads);
		logic [RES_W-1:0] r;
		int unsigned step;
		for (int k = 0; k < rounds; k++) begin
			r = (k == 0) ? '0 : RES_W'($urandom_range(20000, 0));
			for (int i = 0; i < NPOINTS; i++) begin
				if (k == 0 && i == NPOINTS-1)
					r = RES_MAX;
				write_point(IDX_W'(i), r, TEMP_W'($urandom));
				step = ($urandom_range(15, 0) == 0) ? 0 :
					$urandom_range((k == 0) ? 16383 : 8191, 1);
				r = (int'(r) + step > int'(RES_MAX)) ? RES_MAX : RES_W'(int'(r) + step);
			end
			repeat (reads)
				convert_random();
		end
	endtask

	// Edits that mostly keep the table sorted, with some arbitrary writes as noise.
	task automatic test_random_edits(input int beats);
		int unsigned idx;
		logic [RES_W-1:0] lo, hi;
		repeat (beats) begin
			if ($urandom_range(99, 0) < 35) begin
				idx = $urandom_range(NPOINTS-1, 0);
				lo = (idx == 0) ? '0 : cal_res[idx-1];
				hi = (idx == NPOINTS-1) ? RES_MAX : cal_res[idx+1];
				if ($urandom_range(4, 0) != 0 && lo <= hi)
					write_point(IDX_W'(idx), RES_W'($urandom_range(hi, lo)),
						TEMP_W'($urandom));
				else
					write_point(IDX_W'(idx), RES_W'($urandom), TEMP_W'($urandom));
			end else begin
				convert_random();
			end
		end
	endtask

	// Receiver holds off for a long stretch while converts keep coming back to back:
	// the block fills and has to drop item_ready.
	task automatic test_result_backpressure(input int beats);
		idle_enable = 1'b0;
		holds_requested++;
		repeat (beats)
			convert_random();
		idle_enable = 1'b1;
	endtask

	initial begin : sequencer
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		operation <= OP_CONVERT;
		resistance <= '0;
		point_index <= '0;
		point_temperature <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_factory_curve();
		test_point_writes();
		test_random_curves(4, 120);
		test_random_edits(280);
		test_result_backpressure(24);
		test_random_edits(40);
		item_valid <= 1'b0;

		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
